>>> src/sha1_byte_stream_hasher_core_defines.svh
// assertion macros for the sha-1 byte stream hasher
// used by the controller and datapath, expects clk and rst in scope
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// property must hold in the same cycle
`define SHA1BSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHA1BSH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);

`endif

>>> src/sha1bsh_pkg.sv
// shared types and constants for the sha-1 byte stream hasher
// no dependencies
package sha1bsh_pkg;

  localparam int unsigned Rounds      = 80;
  localparam int unsigned DigestWords = 5;

  localparam logic       CMD_ABSORB = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;

  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] FillLen  = 6'd56;
  localparam logic [7:0] PadMark  = 8'h80;

  // index 0 is the first chaining word
  localparam logic [4:0][31:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [3:0][31:0] RoundK = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ZERO  = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PUSH_DATA,
    PUSH_MARK,
    PUSH_ZERO,
    PUSH_LEN
  } push_sel_t;

  typedef struct packed {
    logic      push;
    push_sel_t push_sel;
    logic      count_len;
    logic      round;
    logic [1:0] round_grp;
    logic      add;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_empty;
  } dp_stat_t;

endpackage

>>> src/sha1bsh_ctrl.sv
// controller state machine: byte intake, padding sequence, round count
// depends on sha1bsh_pkg and the assertion macro header
`include "sha1_byte_stream_hasher_core_defines.svh"

module sha1bsh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  output sha1bsh_pkg::dp_cmd_t cmd,
  input  sha1bsh_pkg::dp_stat_t stat
);
  import sha1bsh_pkg::*;

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [6:0] round_cnt, round_cnt_next;
  logic       wrap;

  assign wrap = (stat.fill == FillLast);

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    round_cnt_next = '0;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.push_sel   = PUSH_DATA;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.push = 1'b1;
          if (s_tuser == CMD_ABSORB) begin
            cmd.push_sel  = PUSH_DATA;
            cmd.count_len = 1'b1;
            ret_next      = ST_IDLE;
            if (wrap) state_next = ST_ROUND;
          end else begin
            // the 0x80 marker goes in on the accepting beat
            cmd.push_sel = PUSH_MARK;
            ret_next     = ST_ZERO;
            state_next   = wrap ? ST_ROUND : ST_ZERO;
          end
        end
      end
      ST_ZERO: begin
        if (stat.fill == FillLen) begin
          state_next = ST_LEN;
        end else begin
          cmd.push     = 1'b1;
          cmd.push_sel = PUSH_ZERO;
          if (wrap) begin
            ret_next   = ST_ZERO;
            state_next = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        cmd.push     = 1'b1;
        cmd.push_sel = PUSH_LEN;
        if (wrap) begin
          ret_next   = ST_DONE;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (round_cnt < 7'd20)      cmd.round_grp = 2'd0;
        else if (round_cnt < 7'd40) cmd.round_grp = 2'd1;
        else if (round_cnt < 7'd60) cmd.round_grp = 2'd2;
        else                        cmd.round_grp = 2'd3;
        if (round_cnt == 7'(Rounds - 1)) state_next = ST_ADD;
        else round_cnt_next = round_cnt + 7'd1;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ret;
      end
      ST_DONE: begin
        // wait for the previous digest to drain
        if (stat.out_empty) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      round_cnt <= '0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      round_cnt <= round_cnt_next;
    end
  end

  `SHA1BSH_ASSERT_NEXT(a_round_end, (state == ST_ROUND && round_cnt == 7'(Rounds - 1)), (state == ST_ADD), "compression did not end after the last round")
  `SHA1BSH_ASSERT(a_len_phase, (state == ST_LEN) |-> (stat.fill >= FillLen), "length bytes outside the length slot")
  `SHA1BSH_ASSERT(a_done_aligned, (state == ST_DONE) |-> (stat.fill == 6'd0), "digest ready with a partial block")

endmodule

>>> src/sha1bsh_dp.sv
// datapath: block shift register, schedule, round unit, chaining words,
// length counter and digest output queue; depends on sha1bsh_pkg and macros
`include "sha1_byte_stream_hasher_core_defines.svh"

module sha1bsh_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            data_byte,
  input  sha1bsh_pkg::dp_cmd_t  cmd,
  output sha1bsh_pkg::dp_stat_t stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,
  output logic                  m_tlast
);
  import sha1bsh_pkg::*;

  // block held as 16 big-endian words, word 0 in the top bits
  logic [511:0]      msg;
  logic [60:0]       msg_bytes;
  logic [5:0]        fill;
  logic [4:0][31:0]  chain;
  logic [4:0][31:0]  work;
  logic [4:0][31:0]  chain_sum;
  logic [4:0][31:0]  out_words;
  logic [2:0]        out_count;
  logic [63:0]       bit_len;
  logic [7:0]        push_byte;
  logic [31:0]       w0, sched_new, f, tmp;
  logic [2:0]        len_idx;
  logic              out_beat;

  assign bit_len = {msg_bytes, 3'b000};
  assign len_idx = fill[2:0];
  assign w0      = msg[511:480];

  // words 13, 8, 2 and 0 of the window
  always_comb begin
    logic [31:0] x;
    x         = msg[95:64] ^ msg[255:224] ^ msg[447:416] ^ msg[511:480];
    sched_new = {x[30:0], x[31]};
  end

  always_comb begin
    case (cmd.push_sel)
      PUSH_DATA: push_byte = data_byte;
      PUSH_MARK: push_byte = PadMark;
      PUSH_ZERO: push_byte = 8'h00;
      PUSH_LEN:  push_byte = bit_len[{~len_idx, 3'b000} +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.round_grp)
      2'd0:    f = (work[1] & work[2]) | (~work[1] & work[3]);
      2'd2:    f = (work[1] & work[2]) | (work[1] & work[3]) | (work[2] & work[3]);
      default: f = work[1] ^ work[2] ^ work[3];
    endcase
    tmp = {work[0][26:0], work[0][31:27]} + f + work[4] + RoundK[cmd.round_grp] + w0;
  end

  always_comb begin
    for (int i = 0; i < 5; i++) chain_sum[i] = chain[i] + work[i];
  end

  assign out_beat = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (cmd.push) msg <= {msg[503:0], push_byte};
    else if (cmd.round) msg <= {msg[479:0], sched_new};
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_words <= chain;
    else if (out_beat) out_words <= {32'h0, out_words[4:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bytes <= '0;
      fill      <= '0;
      chain     <= InitChain;
      work      <= InitChain;
      out_count <= '0;
    end else begin
      if (cmd.finish) begin
        msg_bytes <= '0;
        fill      <= '0;
        chain     <= InitChain;
        work      <= InitChain;
        out_count <= 3'(DigestWords);
      end else begin
        if (cmd.count_len) msg_bytes <= msg_bytes + 61'd1;
        if (cmd.push) fill <= fill + 6'd1;
        if (cmd.round) begin
          work[0] <= tmp;
          work[1] <= work[0];
          work[2] <= {work[1][1:0], work[1][31:2]};
          work[3] <= work[2];
          work[4] <= work[3];
        end else if (cmd.add) begin
          chain <= chain_sum;
          work  <= chain_sum;
        end
        if (out_beat) out_count <= out_count - 3'd1;
      end
    end
  end

  assign stat.fill      = fill;
  assign stat.out_empty = (out_count == 3'd0);

  assign m_tvalid = (out_count != 3'd0);
  assign m_tlast  = (out_count == 3'd1);
  assign m_tdata  = {5'b00000, 3'(DigestWords) - out_count, out_words[0]};

  `SHA1BSH_ASSERT(a_load_empty, cmd.finish |-> (out_count == 3'd0), "digest loaded over undelivered words")
  `SHA1BSH_ASSERT_NEXT(a_add_sync, cmd.add, (chain == work), "working words differ from chain after add")
  `SHA1BSH_ASSERT(a_out_bound, (out_count <= 3'(DigestWords)), "output word count out of range")

endmodule

>>> src/sha1_byte_stream_hasher_core.sv
// sha-1 byte stream hasher: input channel s_*, digest channel m_*.
// An input beat carries one message byte (s_tuser = 0) or a finish
// request (s_tuser = 1, s_tdata ignored). A finish pads the message,
// runs the last block(s) and sends the digest as five 32-bit words,
// most significant first, with m_tlast on the fifth.
// An absorb beat that completes a 64-byte block starts a compression
// (80 rounds on the single round unit, then the chaining add) during
// which no beat is taken. After a finish, the padding bytes go in one
// per cycle, paused while a block is compressed, and one or two blocks
// are compressed before the first digest beat; the five words then go
// out one per cycle while m_tready is high.
// Bytes of the next message are taken while the digest drains; a
// second finish waits only if the previous digest is still queued.
// m_tvalid never drops before its beat is taken: a stalled receiver
// just holds the current word. Reset (rst, synchronous) restores the
// initial chaining values and empties the block and the output queue.
// depends on sha1bsh_pkg, sha1bsh_ctrl, sha1bsh_dp
module sha1_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast
);
  import sha1bsh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1bsh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sha1bsh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> tb/sv/sha1_byte_stream_hasher_core_tb.sv
// self-checking testbench for sha1_byte_stream_hasher_core: streams messages byte by byte
// and checks every digest beat against a sha-1 predictor kept in the testbench
// depends on sha1bsh_pkg and the core rtl
module sha1_byte_stream_hasher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1bsh_pkg::*;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  // predictor state
  logic [31:0] hash_chain [5];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_fill;
  logic [60:0] msg_byte_count;

  digest_beat_t digest_q [$];
  int unsigned  fail_count = 0;
  int unsigned  tx_beats = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           rx_hold_req = 1'b0;

  sha1_byte_stream_hasher_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic void clear_hash_state();
    for (int i = 0; i < 5; i++) hash_chain[i] = InitChain[i];
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
    blk_fill       = 6'd0;
    msg_byte_count = 61'd0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] x, a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 16; r < 80; r++) begin
      x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) f = (b & c) | (~b & d);
      else if (r < 40) f = b ^ c ^ d;
      else if (r < 60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      k = RoundK[r / 20];
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void append_block_byte(logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_block();
  endfunction

  function automatic void finish_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    bit_len = {msg_byte_count, 3'b000};
    append_block_byte(PadMark);
    while (blk_fill != FillLen) append_block_byte(8'h00);
    for (int i = 0; i < 8; i++) append_block_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 5; i++) begin
      beat.digest_word = hash_chain[i];
      beat.word_index  = 3'(i);
      beat.last_word   = (i == 4);
      digest_q.push_back(beat);
    end
    clear_hash_state();
  endfunction

  // accepted beats on both sides, sampled at the rising edge
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser == CMD_ABSORB) begin
        append_block_byte(s_tdata);
        msg_byte_count = msg_byte_count + 61'd1;
      end else begin
        finish_message();
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: word %h", m_tdata[31:0]);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (m_tdata[31:0] !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[34:32] !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, m_tdata[34:32]);
          fail_count++;
        end
        if (m_tlast !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold when asked
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance;
  // tvalid stays high between back-to-back beats
  task automatic send_beat(input logic cmd, input logic [7:0] data);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    tx_beats++;
    @(negedge clk);
  endtask

  task automatic send_random_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(CMD_ABSORB, 8'($urandom));
    // data lines carry noise on a finish
    send_beat(CMD_FINISH, 8'($urandom));
  endtask

  // mostly short messages, with lengths around the padding boundaries and a few that pad to two or three blocks
  function automatic int unsigned pick_msg_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 10);
      6, 7:             return $urandom_range(54, 65);
      8:                return 0;
      default:          return $urandom_range(117, 130);
    endcase
  endfunction

  // messages until the beat budget is used, the last one cut to fit
  task automatic send_message_run(input int unsigned n_beats);
    int unsigned stop_at;
    int unsigned len;
    stop_at = tx_beats + n_beats;
    while (tx_beats < stop_at) begin
      len = pick_msg_len();
      if (tx_beats + len + 1 > stop_at) len = stop_at - tx_beats - 1;
      send_random_message(len);
    end
  endtask

  task automatic test_known_vectors();
    send_beat(CMD_FINISH, 8'h00);            // empty message
    send_beat(CMD_ABSORB, 8'h61);
    send_beat(CMD_ABSORB, 8'h62);
    send_beat(CMD_ABSORB, 8'h63);
    send_beat(CMD_FINISH, 8'hff);
    send_beat(CMD_ABSORB, 8'h00);
    send_beat(CMD_FINISH, 8'h5a);
    send_beat(CMD_ABSORB, 8'hff);
    send_beat(CMD_FINISH, 8'ha5);
    send_beat(CMD_FINISH, 8'hff);            // back-to-back finishes
    send_beat(CMD_FINISH, 8'h00);
  endtask

  task automatic test_random_messages(input int unsigned n_beats);
    send_message_run(n_beats);
  endtask

  // the digest queue fills while the receiver is held off, so finishes must back up
  task automatic test_output_pressure();
    rx_hold_req = 1'b1;
    for (int i = 0; i < 5; i++) send_random_message($urandom_range(0, 4));
  endtask

  task automatic test_tail_streaming(input int unsigned n_beats);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_message_run(n_beats);
  endtask

  initial begin
    clear_hash_state();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = CMD_ABSORB;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_known_vectors();
    test_random_messages(130);
    test_output_pressure();
    test_tail_streaming(60);

    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_byte_stream_hasher_core: match");
    end else begin
      $display("sha1_byte_stream_hasher_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sha1_byte_stream_hasher_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/sha1bsh_pkg.sv
src/sha1bsh_ctrl.sv
src/sha1bsh_dp.sv
src/sha1_byte_stream_hasher_core.sv
tb/sv/sha1_byte_stream_hasher_core_tb.sv
